// ===== src/icrm_pkg.sv =====
// package for the int8 conv1d requant maxpool core: commands and row helpers
`timescale 1ns / 1ps
package icrm_pkg;
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_WEIGHT = 2'd1,
		CMD_BIAS   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_IN_CH  = 2'd0,
		REG_OUT_CH = 2'd1,
		REG_SHIFT  = 2'd2,
		REG_RELU   = 2'd3
	} reg_idx_t;

	localparam logic signed [7:0] QMAX = 8'sd127;
	localparam logic signed [7:0] QMIN = -8'sd127;
	localparam logic signed [7:0] POOL_INIT = -8'sd128;
	localparam int ACC_W = 48;

	// controller to datapath
	typedef struct packed {
		logic       clr_acc;    // load bias for a new output
		logic       mac;        // one multiply-accumulate step
		logic       fold;       // requantise and fold into running max
		logic       shift_hist; // push current sample into history
		logic       clear_row;  // clear history and pool maxima
		logic       reset_max;  // pool window emitted
	} dp_cmd_t;
endpackage

// ===== src/icrm_datapath.sv =====
// datapath: coefficient stores, sample window, one shared mac and pooling maxima
`timescale 1ns / 1ps
module icrm_datapath import icrm_pkg::*; #(
	parameter int MAX_IN_CH  = 8,
	parameter int MAX_OUT_CH = 8,
	parameter int TAPS       = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	input  logic                          wr_weight,
	input  logic                          wr_bias,
	input  logic [8:0]                    table_index,
	input  logic signed [31:0]            table_value,
	input  logic signed [7:0]             cur_sample [8],
	input  logic [$clog2(MAX_IN_CH)-1:0]  ic,
	input  logic [$clog2(TAPS)-1:0]       tap,
	input  logic [$clog2(TAPS)-1:0]       win_pos,
	input  logic [$clog2(MAX_OUT_CH)-1:0] oc,
	input  logic [4:0]                    shift_bits,
	input  logic                          relu_on,
	output logic signed [7:0]             max_value
);
	localparam int NW  = MAX_OUT_CH * MAX_IN_CH * TAPS;
	localparam int OCW = $clog2(MAX_OUT_CH);
	localparam int WAW = $clog2(NW);

	logic signed [7:0]  weight_mem [NW];
	logic signed [31:0] bias_q [MAX_OUT_CH];
	logic signed [7:0]  hist_q [TAPS-1][MAX_IN_CH];
	logic signed [7:0]  maxv_q [MAX_OUT_CH];
	logic signed [7:0]  w_rd_q;
	logic signed [7:0]  x_q;
	logic               x_v_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [WAW-1:0]     w_addr;
	logic signed [7:0]  x_sel;
	logic               x_valid;
	logic signed [ACC_W-1:0] rnd, shifted;
	logic signed [7:0]  q;

	assign w_addr = WAW'((int'(oc) * MAX_IN_CH + int'(ic)) * TAPS + int'(tap));

	// window slot win_pos: history row or current sample, zero beyond the window
	always_comb begin
		x_valid = (int'(win_pos) + int'(tap)) < TAPS;
		x_sel = '0;
		if (x_valid) begin
			if ((int'(win_pos) + int'(tap)) == TAPS - 1)
				x_sel = (int'(ic) < 8) ? cur_sample[3'(ic)] : '0;
			else
				x_sel = hist_q[$clog2(TAPS-1)'(int'(win_pos) + int'(tap))][ic];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_weight && int'(table_index) < NW)
			weight_mem[WAW'(table_index)] <= table_value[7:0];
		w_rd_q <= weight_mem[w_addr];
		x_q <= x_sel;
		x_v_q <= x_valid;
		if (wr_bias && int'(table_index) < MAX_OUT_CH)
			bias_q[OCW'(table_index)] <= table_value;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_acc)
			acc_q <= ACC_W'(bias_q[oc]);
		else if (cmd.mac && x_v_q)
			acc_q <= acc_q + ACC_W'(x_q * w_rd_q);
	end

	always_comb begin
		rnd = acc_q;
		if (shift_bits != 5'd0)
			rnd = acc_q + (ACC_W'(1) <<< (shift_bits - 5'd1));
		shifted = rnd >>> shift_bits;
		if (shifted > ACC_W'(127)) q = QMAX;
		else if (shifted < -ACC_W'(127)) q = QMIN;
		else q = shifted[7:0];
		if (relu_on && q < 0) q = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS-1; i++)
				for (int j = 0; j < MAX_IN_CH; j++) hist_q[i][j] <= '0;
			for (int i = 0; i < MAX_OUT_CH; i++) maxv_q[i] <= POOL_INIT;
		end else begin
			if (cmd.clear_row) begin
				for (int i = 0; i < TAPS-1; i++)
					for (int j = 0; j < MAX_IN_CH; j++) hist_q[i][j] <= '0;
			end else if (cmd.shift_hist) begin
				for (int i = 0; i < TAPS-2; i++) hist_q[i] <= hist_q[i+1];
				for (int j = 0; j < MAX_IN_CH; j++)
					hist_q[TAPS-2][j] <= (j < 8) ? cur_sample[j % 8] : '0;
			end
			if (cmd.reset_max || cmd.clear_row) begin
				for (int i = 0; i < MAX_OUT_CH; i++) maxv_q[i] <= POOL_INIT;
			end else if (cmd.fold && q > maxv_q[oc]) begin
				maxv_q[oc] <= q;
			end
		end
	end

	assign max_value = maxv_q[oc];
endmodule

// ===== src/icrm_ctrl.sv =====
// controller: sequences mac steps, pooling and result words per input word
`timescale 1ns / 1ps
module icrm_ctrl import icrm_pkg::*; #(
	parameter int MAX_IN_CH   = 8,
	parameter int MAX_OUT_CH  = 8,
	parameter int TAPS        = 5,
	parameter int POOL_LEN    = 5,
	parameter int MAX_ROW_LEN = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    in_cmd,
	input  logic                          in_eor,
	input  logic [3:0]                    in_channels,
	input  logic [3:0]                    out_channels,
	output logic                          wr_weight,
	output logic                          wr_bias,
	output logic                          sample_load,
	output dp_cmd_t                       cmd,
	output logic [$clog2(MAX_IN_CH)-1:0]  ic,
	output logic [$clog2(TAPS)-1:0]       tap,
	output logic [$clog2(TAPS)-1:0]       win_pos,
	output logic [$clog2(MAX_OUT_CH)-1:0] oc,
	input  logic signed [7:0]             max_value,
	output logic                          o_valid,
	input  logic                          o_stall,
	output logic [2:0]                    o_channel,
	output logic signed [7:0]             o_value,
	output logic                          o_last,
	output logic                          o_done
);
	localparam int PAD  = (TAPS - 1) / 2;
	localparam int RPAD = TAPS - 1 - PAD;
	localparam int PCW  = $clog2(MAX_ROW_LEN);
	localparam int PHW  = $clog2(POOL_LEN + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_POS, S_BIAS, S_MAC, S_DRAIN, S_FOLD, S_NEXTOC, S_EMIT, S_WAIT, S_ENDPOS, S_END
	} state_t;

	state_t         state_q;
	logic [PCW-1:0] pos_q;
	logic [PHW-1:0] phase_q;
	logic           eor_q;
	logic [4:0]     nin, nout;

	always_comb begin
		nin = (in_channels == 4'd0) ? 5'd1 :
			(int'(in_channels) > MAX_IN_CH) ? 5'(MAX_IN_CH) : {1'b0, in_channels};
		nout = (out_channels == 4'd0) ? 5'd1 :
			(int'(out_channels) > MAX_OUT_CH) ? 5'(MAX_OUT_CH) : {1'b0, out_channels};
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		wr_weight = 1'b0;
		wr_bias = 1'b0;
		sample_load = 1'b0;
		if (state_q == S_IDLE && in_valid) begin
			wr_weight = (in_cmd == CMD_WEIGHT);
			wr_bias = (in_cmd == CMD_BIAS);
			sample_load = (in_cmd == CMD_SAMPLE);
		end
		cmd = '0;
		cmd.clr_acc = (state_q == S_BIAS);
		cmd.mac = (state_q == S_MAC && !(ic == '0 && tap == '0)) || state_q == S_DRAIN;
		cmd.fold = (state_q == S_FOLD);
		cmd.reset_max = (state_q == S_WAIT && !o_stall && o_last);
		cmd.shift_hist = (state_q == S_END && !eor_q);
		cmd.clear_row = (state_q == S_END && eor_q);
	end

	assign o_valid = (state_q == S_WAIT);
	assign o_value = max_value;
	assign o_channel = 3'(oc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= '0;
			phase_q <= '0;
			eor_q <= 1'b0;
			ic <= '0; tap <= '0; win_pos <= '0; oc <= '0;
			o_last <= 1'b0; o_done <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid && in_cmd == CMD_SAMPLE) begin
					eor_q <= in_eor;
					win_pos <= '0;
					state_q <= S_POS;
				end
				S_POS: begin
					oc <= '0;
					if (int'(pos_q) + int'(win_pos) < RPAD) state_q <= S_ENDPOS;
					else state_q <= S_BIAS;
				end
				S_BIAS: begin
					ic <= '0; tap <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (int'(tap) == TAPS - 1) begin
						tap <= '0;
						if (5'(ic) + 5'd1 == nin) state_q <= S_DRAIN;
						else ic <= ic + 1'b1;
					end else tap <= tap + 1'b1;
				end
				S_DRAIN: state_q <= S_FOLD;
				S_FOLD: state_q <= S_NEXTOC;
				S_NEXTOC: begin
					if (5'(oc) + 5'd1 == nout) begin
						oc <= '0;
						if (int'(phase_q) + 1 >= POOL_LEN) begin
							phase_q <= '0;
							o_last <= (nout == 5'd1);
							o_done <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							phase_q <= phase_q + 1'b1;
							state_q <= S_ENDPOS;
						end
					end else begin
						oc <= oc + 1'b1;
						state_q <= S_BIAS;
					end
				end
				S_EMIT: begin
					// row_done goes on once the last window of this word is known
					if (eor_q && int'(win_pos) + POOL_LEN > RPAD) o_done <= 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: if (!o_stall) begin
					if (o_last) begin
						oc <= '0;
						o_last <= 1'b0;
						state_q <= S_ENDPOS;
					end else begin
						oc <= oc + 1'b1;
						o_last <= (5'(oc) + 5'd2 == nout);
						state_q <= S_EMIT;
					end
				end
				S_ENDPOS: begin
					if (eor_q && int'(win_pos) < RPAD) begin
						win_pos <= win_pos + 1'b1;
						state_q <= S_POS;
					end else state_q <= S_END;
				end
				S_END: begin
					if (eor_q) begin
						pos_q <= '0;
						phase_q <= '0;
					end else if (int'(pos_q) < MAX_ROW_LEN - 1) pos_q <= pos_q + 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/int8_conv1d_requant_maxpool_core.sv =====
// top level of the int8 conv1d requant maxpool core
`timescale 1ns / 1ps
// usage
// input channel: in_valid / in_stall; a word is taken when valid is high and stall low
// cmd 1 writes a weight, cmd 2 a bias; cmd 3 is dropped
// cmd 0 brings one row position; its output (two positions back) is computed
// by one shared multiplier, one tap per cycle
// an end_of_row word also flushes the right padding, up to two further positions
// each completed pool window gives out_channels result words on out_valid / out_stall;
// the sequencer waits while the receiver stalls
// the input is stalled for the whole time a position is worked on
// config writes use cfg_valid / cfg_ready / cfg_index / cfg_data, only while idle
// reset clears sample history, position count, pool phase and maxima at once;
// weight and bias stores hold nothing defined until written
module int8_conv1d_requant_maxpool_core import icrm_pkg::*; #(
	parameter int MAX_IN_CH   = 8,
	parameter int MAX_OUT_CH  = 8,
	parameter int TAPS        = 5,
	parameter int POOL_LEN    = 5,
	parameter int MAX_ROW_LEN = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [8:0]         table_index,
	input  logic signed [31:0] table_value,
	input  logic signed [7:0]  sample_0,
	input  logic signed [7:0]  sample_1,
	input  logic signed [7:0]  sample_2,
	input  logic signed [7:0]  sample_3,
	input  logic signed [7:0]  sample_4,
	input  logic signed [7:0]  sample_5,
	input  logic signed [7:0]  sample_6,
	input  logic signed [7:0]  sample_7,
	input  logic               end_of_row,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         out_channel,
	output logic signed [7:0]  pooled_value,
	output logic               last_of_run,
	output logic               row_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	logic [3:0] in_ch_q, out_ch_q;
	logic [4:0] shift_q;
	logic       relu_q;
	logic       wr_w, wr_b, s_load;
	dp_cmd_t    dcmd;
	logic [$clog2(MAX_IN_CH)-1:0]  ic;
	logic [$clog2(TAPS)-1:0]       tap, win_pos;
	logic [$clog2(MAX_OUT_CH)-1:0] oc;
	logic signed [7:0] maxv;
	logic signed [7:0] smp_q [8];

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q <= 4'd1; out_ch_q <= 4'd1; shift_q <= '0; relu_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_CH:  in_ch_q <= cfg_data[3:0];
				REG_OUT_CH: out_ch_q <= cfg_data[3:0];
				REG_SHIFT:  shift_q <= cfg_data[4:0];
				REG_RELU:   relu_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// current position held for the whole computation
	always_ff @(posedge clk) begin
		if (s_load) begin
			smp_q[0] <= sample_0; smp_q[1] <= sample_1;
			smp_q[2] <= sample_2; smp_q[3] <= sample_3;
			smp_q[4] <= sample_4; smp_q[5] <= sample_5;
			smp_q[6] <= sample_6; smp_q[7] <= sample_7;
		end
	end

	icrm_ctrl #(.MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH), .TAPS(TAPS),
		.POOL_LEN(POOL_LEN), .MAX_ROW_LEN(MAX_ROW_LEN)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_cmd(cmd), .in_eor(end_of_row),
		.in_channels(in_ch_q), .out_channels(out_ch_q),
		.wr_weight(wr_w), .wr_bias(wr_b), .sample_load(s_load), .cmd(dcmd),
		.ic, .tap, .win_pos, .oc, .max_value(maxv),
		.o_valid(out_valid), .o_stall(out_stall), .o_channel(out_channel),
		.o_value(pooled_value), .o_last(last_of_run), .o_done(row_done)
	);

	icrm_datapath #(.MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH), .TAPS(TAPS)) u_dp (
		.clk, .arst_n, .cmd(dcmd), .wr_weight(wr_w), .wr_bias(wr_b),
		.table_index, .table_value, .cur_sample(smp_q), .ic, .tap, .win_pos, .oc,
		.shift_bits(shift_q), .relu_on(relu_q), .max_value(maxv)
	);
endmodule

// ===== src/icrm_checker.sv =====
// port-level checker for the conv1d maxpool core, bound to the top level
`timescale 1ns / 1ps
module icrm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [2:0]        out_channel,
	input logic signed [7:0] pooled_value,
	input logic              last_of_run
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pooled_value))
		else $error("stalled result word changed");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pooled_value != -8'sd128)
		else $error("pooled value out of range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while emitting");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> ##1 out_channel == $past(out_channel, 2) + 3'd1)
		else $error("channel order broken");
endmodule

bind int8_conv1d_requant_maxpool_core icrm_checker u_icrm_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.out_channel, .pooled_value, .last_of_run
);

// ===== tb/int8_conv1d_requant_maxpool_core_test.sv =====
// testbench for the int8 conv1d requant maxpool core: queued stimulus, predictor, checker
`timescale 1ns / 1ps
module int8_conv1d_requant_maxpool_core_test;
	import icrm_pkg::*;

	localparam int N_IN     = 8;
	localparam int N_OUT    = 8;
	localparam int N_TAP    = 5;
	localparam int N_POOL   = 5;
	localparam int ROW_MAX  = 4096;
	localparam int N_WEIGHT = N_OUT * N_IN * N_TAP;
	localparam int SETTLE   = 1500;    // cycles after the last result before a config write
	localparam int LIMIT    = 3000000; // cycle budget for the whole run
	localparam int HOLD_AT  = 20;      // result count at which the receiver holds off
	localparam int HOLD_LEN = 2000;

	// one input word as it goes onto the channel
	typedef struct {
		cmd_t                cmd;
		logic [8:0]          index;
		logic signed [31:0]  value;
		logic signed [7:0]   smp [N_IN];
		logic                eor;
	} in_word_t;

	// one pooled result word
	typedef struct {
		logic [2:0]         channel;
		logic signed [7:0]  value;
		logic               last;
		logic               done;
	} pooled_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_NONE;
	logic [8:0]         table_index = '0;
	logic signed [31:0] table_value = '0;
	logic signed [7:0]  sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
	logic signed [7:0]  sample_4 = '0, sample_5 = '0, sample_6 = '0, sample_7 = '0;
	logic               end_of_row = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         out_channel;
	logic signed [7:0]  pooled_value;
	logic               last_of_run;
	logic               row_done;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	int8_conv1d_requant_maxpool_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .table_index(table_index), .table_value(table_value),
		.sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
		.sample_4(sample_4), .sample_5(sample_5), .sample_6(sample_6), .sample_7(sample_7),
		.end_of_row(end_of_row),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_channel(out_channel), .pooled_value(pooled_value),
		.last_of_run(last_of_run), .row_done(row_done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// predictor state: tables, row history and pooling, register copies
	logic signed [7:0]  wt_tab [N_WEIGHT];
	logic signed [31:0] bias_tab [N_OUT];
	logic signed [7:0]  hist [N_TAP-1][N_IN];
	int                 row_pos;
	int                 pool_cnt;
	int                 run_max [N_OUT];
	logic [3:0]         in_ch_reg = 4'd1;
	logic [3:0]         out_ch_reg = 4'd1;
	logic [4:0]         shift_reg = 5'd0;
	logic               relu_reg = 1'b0;

	in_word_t word_queue [$];   // words still to be offered
	pooled_t  pooled_due [$];   // pooled results not yet seen
	in_word_t cur_word;
	int       gap_left = 0;
	int       stall_left = 0;
	int       results_seen = 0;
	int       errors = 0;
	int       cycles = 0;
	bit       quiet = 1'b0;     // no idling on either side while set

	function automatic int eff_count(input logic [3:0] v);
		if (v == 0)
			return 1;
		return (v > 8) ? 8 : int'(v);
	endfunction

	// round half up, clamp to the symmetric int8 range, optional relu
	function automatic int requantise(input longint acc);
		longint r;
		r = acc;
		if (shift_reg != 0)
			r = (acc + (longint'(1) <<< (shift_reg - 1))) >>> shift_reg;
		if (r > 127) r = 127;
		if (r < -127) r = -127;
		if (relu_reg && r < 0) r = 0;
		return int'(r);
	endfunction

	function automatic void clear_row_state();
		foreach (hist[k, c]) hist[k][c] = '0;
		row_pos = 0;
		pool_cnt = 0;
		foreach (run_max[c]) run_max[c] = -128;
	endfunction

	// apply one accepted word to the predictor, queue the pooled words it yields
	function automatic void fold_position(input in_word_t w);
		logic signed [7:0] win [N_TAP][N_IN];
		pooled_t           res [$];
		pooled_t           p;
		longint            acc;
		int                nin, nout, dmax, v, last_start;
		last_start = -1;
		if (w.cmd == CMD_WEIGHT) begin
			if (w.index < N_WEIGHT) wt_tab[w.index] = w.value[7:0];
			return;
		end
		if (w.cmd == CMD_BIAS) begin
			if (w.index < N_OUT) bias_tab[w.index[2:0]] = w.value;
			return;
		end
		if (w.cmd != CMD_SAMPLE)
			return;
		nin = eff_count(in_ch_reg);
		nout = eff_count(out_ch_reg);
		for (int k = 0; k < N_TAP - 1; k++)
			for (int c = 0; c < N_IN; c++) win[k][c] = hist[k][c];
		for (int c = 0; c < N_IN; c++) win[N_TAP-1][c] = w.smp[c];
		dmax = w.eor ? 2 : 0;
		for (int d = 0; d <= dmax; d++) begin
			if (row_pos - 2 + d < 0)
				continue;
			for (int oc = 0; oc < nout; oc++) begin
				acc = bias_tab[oc];
				for (int ic = 0; ic < nin; ic++)
					for (int k = 0; k + d < N_TAP; k++)
						acc += longint'(win[d+k][ic]) * longint'(wt_tab[oc*N_IN*N_TAP + ic*N_TAP + k]);
				v = requantise(acc);
				if (v > run_max[oc]) run_max[oc] = v;
			end
			pool_cnt++;
			if (pool_cnt >= N_POOL) begin
				last_start = res.size();
				for (int oc = 0; oc < nout; oc++) begin
					p.channel = oc[2:0];
					p.value = run_max[oc][7:0];
					p.last = (oc == nout - 1);
					p.done = 1'b0;
					res.push_back(p);
				end
				foreach (run_max[c]) run_max[c] = -128;
				pool_cnt = 0;
			end
		end
		if (w.eor) begin
			// only the window closed by the end of row word carries row_done
			if (last_start >= 0)
				for (int r = last_start; r < res.size(); r++) res[r].done = 1'b1;
			clear_row_state();
		end else begin
			for (int k = 0; k < N_TAP - 2; k++)
				for (int c = 0; c < N_IN; c++) hist[k][c] = hist[k+1][c];
			for (int c = 0; c < N_IN; c++) hist[N_TAP-2][c] = w.smp[c];
			if (row_pos < ROW_MAX - 1) row_pos++;
		end
		foreach (res[r]) pooled_due.push_back(res[r]);
	endfunction

	// sender: one word at a time from the queue, random gap after each accepted word
	always @(posedge clk) begin
		bit offer;
		offer = in_valid;
		if (in_valid && !in_stall) begin
			fold_position(cur_word);
			offer = 1'b0;
			gap_left = quiet ? 0 : $urandom_range(0, 9);
		end
		if (!offer && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (word_queue.size() > 0) begin
				cur_word = word_queue.pop_front();
				offer = 1'b1;
				cmd <= cur_word.cmd;
				table_index <= cur_word.index;
				table_value <= cur_word.value;
				sample_0 <= cur_word.smp[0];
				sample_1 <= cur_word.smp[1];
				sample_2 <= cur_word.smp[2];
				sample_3 <= cur_word.smp[3];
				sample_4 <= cur_word.smp[4];
				sample_5 <= cur_word.smp[5];
				sample_6 <= cur_word.smp[6];
				sample_7 <= cur_word.smp[7];
				end_of_row <= cur_word.eor;
			end
		end
		in_valid <= offer;
	end

	// receiver: compare each taken word with the oldest prediction, then stall a while
	always @(posedge clk) begin
		pooled_t e;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (pooled_due.size() == 0) begin
				$error("unexpected pooled word: channel %0d value %0d", out_channel, pooled_value);
				errors++;
			end else begin
				e = pooled_due.pop_front();
				if (out_channel !== e.channel) begin
					$error("out_channel: expected %0d, got %0d", e.channel, out_channel);
					errors++;
				end
				if (pooled_value !== e.value) begin
					$error("pooled_value: expected %0d, got %0d", e.value, pooled_value);
					errors++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run: expected %0b, got %0b", e.last, last_of_run);
					errors++;
				end
				if (row_done !== e.done) begin
					$error("row_done: expected %0b, got %0b", e.done, row_done);
					errors++;
				end
			end
			// one long hold-off so the core backs up and stalls its input
			if (results_seen == HOLD_AT)
				stall_left = HOLD_LEN;
			else
				stall_left = quiet ? 0 : $urandom_range(0, 9);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_IN_CH:  in_ch_reg = data[3:0];
			REG_OUT_CH: out_ch_reg = data[3:0];
			REG_SHIFT:  shift_reg = data[4:0];
			REG_RELU:   relu_reg = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input int in_ch, input int out_ch, input int sh, input int relu);
		write_reg(REG_IN_CH, in_ch);
		write_reg(REG_OUT_CH, out_ch);
		write_reg(REG_SHIFT, sh);
		write_reg(REG_RELU, relu);
	endtask

	// wait for the queue and the core to empty, then let the core settle
	task automatic drain();
		@(posedge clk);
		while (word_queue.size() != 0 || in_valid || pooled_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return -8'sd128;
			1: return 8'sd127;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic void push_table(input cmd_t c, input int idx, input logic [31:0] val);
		in_word_t w;
		w.cmd = c;
		w.index = 9'(idx);
		w.value = val;
		foreach (w.smp[i]) w.smp[i] = 8'($urandom());
		w.eor = 1'($urandom_range(0, 1));
		word_queue.push_back(w);
	endfunction

	// fill = 1 random, 2 all max, 3 all min
	function automatic void push_row(input int len, input int fill);
		in_word_t w;
		for (int i = 0; i < len; i++) begin
			w.cmd = CMD_SAMPLE;
			w.index = 9'($urandom());
			w.value = $urandom();
			foreach (w.smp[c])
				w.smp[c] = (fill == 2) ? 8'sd127 : (fill == 3) ? -8'sd128 : rand_byte();
			w.eor = (i == len - 1);
			word_queue.push_back(w);
		end
	endfunction

	function automatic logic [31:0] rand_bias();
		if ($urandom_range(0, 7) == 0)
			return $urandom();
		return $urandom_range(0, 16383) - 8192;
	endfunction

	initial begin
		int len, budget;
		clear_row_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// fill both tables first, so no unwritten entry is ever read
		quiet = 1'b1;
		for (int i = 0; i < N_WEIGHT; i++) push_table(CMD_WEIGHT, i, $urandom());
		for (int i = 0; i < N_OUT; i++) push_table(CMD_BIAS, i, rand_bias());
		drain();

		// directed: extreme rows, lone position, window closing ahead of the row end
		quiet = 1'b0;
		set_regs(8, 8, 9, 0);
		push_row(5, 2);
		push_row(5, 3);
		push_row(1, 1);
		push_row(8, 1);
		push_table(CMD_NONE, 5, 32'hffff_ffff);
		push_table(CMD_WEIGHT, 400, 32'h1234_5680);   // out of range, dropped
		push_table(CMD_BIAS, 9, 32'h7fff_ffff);       // out of range, dropped
		push_table(CMD_WEIGHT, 3, 32'h8765_43ff);     // only the low byte lands
		push_table(CMD_BIAS, 0, 32'h8000_0000);
		push_table(CMD_BIAS, 1, 32'h7fff_ffff);
		push_row(3, 1);
		drain();
		push_table(CMD_BIAS, 0, rand_bias());
		push_table(CMD_BIAS, 1, rand_bias());
		drain();

		// random phases: the extremes first, then random settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_regs(0, 0, 0, 0);
				1: set_regs(15, 15, 31, 1);
				2: set_regs(8, 8, 1, 0);
				3: set_regs(3, 5, 10, 1);
				default: set_regs($urandom_range(0, 15), $urandom_range(0, 15),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(6, 14),
					$urandom_range(0, 1));
			endcase
			quiet = (ph == 5);
			budget = 12;
			while (budget > 0) begin
				case ($urandom_range(0, 9))
					0: push_table(CMD_WEIGHT, $urandom_range(0, 511), $urandom());
					1: push_table(CMD_BIAS, $urandom_range(0, 15), rand_bias());
					2: push_table(CMD_NONE, $urandom_range(0, 511), $urandom());
					default: begin
						len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 30)
							: $urandom_range(1, 16);
						push_row(len, 1);
						budget -= len - 1;
					end
				endcase
				budget--;
			end
			drain();
		end

		if (pooled_due.size() != 0) begin
			$error("%0d pooled words never arrived", pooled_due.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
src/icrm_pkg.sv
src/icrm_datapath.sv
src/icrm_ctrl.sv
src/int8_conv1d_requant_maxpool_core.sv
src/icrm_checker.sv
tb/int8_conv1d_requant_maxpool_core_test.sv
